// ===== sv/complex_arithmetic_unit_macros.svh =====
// Assertion macros for the complex arithmetic unit checker.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Clocked assertion, quiet during reset.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Signal holds across a stalled output cycle.
`define CAU_ASSERT_STABLE(lbl, sig, msg) \
  `CAU_ASSERT(lbl, out_valid && out_stall |=> $stable(sig), msg)

`endif

// ===== sv/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, widths and helpers for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int DATA_W    = 32;
  localparam int SAT_BITS  = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int QUO_W     = DATA_W;
  localparam int NUM_W     = PROD_W + FRAC_BITS;
  localparam int REMI_W    = NUM_W - QUO_W;
  localparam int CNT_W     = $clog2(QUO_W + 1);
  localparam int Q_DEPTH   = 2;
  localparam int QPTR_W    = $clog2(Q_DEPTH);
  localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] FN_ADD = 2'd0;
  localparam logic [1:0] FN_SUB = 2'd1;
  localparam logic [1:0] FN_MUL = 2'd2;
  localparam logic [1:0] FN_DIV = 2'd3;

  typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DZ} op_t;

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_DONE} div_state_t;

  typedef struct packed {
    op_t                       op;
    logic signed [DATA_W-1:0]  a_re;
    logic signed [DATA_W-1:0]  a_im;
    logic signed [DATA_W-1:0]  b_re;
    logic signed [DATA_W-1:0]  b_im;
  } item_t;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } sat_t;

  function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
  endfunction

  // Clamp a sign-magnitude value to SAT_BITS, result sign-extended to DATA_W.
  function automatic sat_t sat_mag(input logic neg, input logic [ACC_W-1:0] mag,
                                   input logic big);
    logic [ACC_W-1:0] lim;
    logic [ACC_W-1:0] m;
    sat_t             r;
    lim   = ACC_W'(1) << (SAT_BITS - 1);
    r.ovf = 1'b0;
    m     = mag;
    if (neg) begin
      if (big || mag > lim) begin
        m     = lim;
        r.ovf = 1'b1;
      end
      r.val = DATA_W'(ACC_W'(0) - m);
    end else begin
      if (big || mag > lim - ACC_W'(1)) begin
        m     = lim - ACC_W'(1);
        r.ovf = 1'b1;
      end
      r.val = DATA_W'(m);
    end
    return r;
  endfunction

endpackage

// ===== sv/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Takes input transfers, decodes the operation and flags zero divisors.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   func,
  input  logic signed [cau_pkg::DATA_W-1:0] a_re,
  input  logic signed [cau_pkg::DATA_W-1:0] a_im,
  input  logic signed [cau_pkg::DATA_W-1:0] b_re,
  input  logic signed [cau_pkg::DATA_W-1:0] b_im,
  input  logic                         q_full,
  output logic                         push,
  output cau_pkg::item_t               push_item
);
  import cau_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.a_re = a_re;
    push_item.a_im = a_im;
    push_item.b_re = b_re;
    push_item.b_im = b_im;
    unique case (func)
      FN_ADD:  push_item.op = OP_ADD;
      FN_SUB:  push_item.op = OP_SUB;
      FN_MUL:  push_item.op = OP_MUL;
      FN_DIV:  push_item.op = (b_re == '0 && b_im == '0) ? OP_DZ : OP_DIV;
      default: push_item.op = OP_ADD;
    endcase
  end

endmodule

// ===== sv/cau_queue.sv =====
// ----------------------------------------------------------------------------
// cau_queue
// Small FIFO decoupling the decode side from the arithmetic side.
// ----------------------------------------------------------------------------
module cau_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cau_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output cau_pkg::item_t head
);
  import cau_pkg::*;

  item_t             entry [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(Q_DEPTH));
  assign valid = (count != '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back
// Product stage, combine/saturate, two-lane restoring divider, output register.
// ----------------------------------------------------------------------------
module cau_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  cau_pkg::item_t                    q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cau_pkg::DATA_W-1:0] res_re,
  output logic signed [cau_pkg::DATA_W-1:0] res_im,
  output logic                              overflow,
  output logic                              div_zero
);
  import cau_pkg::*;

  // product stage
  logic                     v1;
  op_t                      op1;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  logic signed [DATA_W:0]   sum_re, sum_im;

  logic signed [PROD_W-1:0] m_rr, m_ii, m_ri, m_ir, m_sr, m_si;

  // divider
  div_state_t               dv_state, dv_state_next;
  logic [CNT_W-1:0]         cnt;
  logic [PROD_W-1:0]        rem [2];
  logic [QUO_W-1:0]         shf [2];
  logic [QUO_W-1:0]         quo [2];
  logic                     big [2];
  logic                     dneg [2];

  logic [PROD_W-1:0]        den;
  logic signed [ACC_W-1:0]  mul_re, mul_im, div_nr, div_ni;
  logic [ACC_W-1:0]         dmag [2];
  logic [NUM_W-1:0]         dnum [2];
  logic [REMI_W-1:0]        rem_init [2];
  logic [PROD_W:0]          trial [2];

  logic                     out_free, s1_adv, dv_start;
  logic                     r_neg, i_neg;
  logic [ACC_W-1:0]         r_mag, i_mag;
  logic                     r_big, i_big;
  sat_t                     r_sat, i_sat;

  assign m_rr = q_item.a_re * q_item.b_re;
  assign m_ii = q_item.a_im * q_item.b_im;
  assign m_ri = q_item.a_re * q_item.b_im;
  assign m_ir = q_item.a_im * q_item.b_re;
  assign m_sr = q_item.b_re * q_item.b_re;
  assign m_si = q_item.b_im * q_item.b_im;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = v1 && out_free && (op1 != OP_DIV || dv_state == DV_DONE);
  assign q_pop    = q_valid && (!v1 || s1_adv);
  assign dv_start = v1 && op1 == OP_DIV && dv_state == DV_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (q_pop) begin
      v1 <= 1'b1;
    end else if (s1_adv) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op1  <= q_item.op;
      p_rr <= m_rr;
      p_ii <= m_ii;
      p_ri <= m_ri;
      p_ir <= m_ir;
      sq_r <= m_sr;
      sq_i <= m_si;
      if (q_item.op == OP_SUB) begin
        sum_re <= (DATA_W+1)'(q_item.a_re) - (DATA_W+1)'(q_item.b_re);
        sum_im <= (DATA_W+1)'(q_item.a_im) - (DATA_W+1)'(q_item.b_im);
      end else begin
        sum_re <= (DATA_W+1)'(q_item.a_re) + (DATA_W+1)'(q_item.b_re);
        sum_im <= (DATA_W+1)'(q_item.a_im) + (DATA_W+1)'(q_item.b_im);
      end
    end
  end

  assign mul_re = ACC_W'(p_rr) - ACC_W'(p_ii);
  assign mul_im = ACC_W'(p_ri) + ACC_W'(p_ir);
  assign div_nr = ACC_W'(p_rr) + ACC_W'(p_ii);
  assign div_ni = ACC_W'(p_ir) - ACC_W'(p_ri);
  assign den    = PROD_W'(sq_r) + PROD_W'(sq_i);

  // numerator scaled by 2^FRAC_BITS; top part seeds the remainder
  always_comb begin
    dmag[0] = abs_acc(div_nr);
    dmag[1] = abs_acc(div_ni);
    for (int k = 0; k < 2; k++) begin
      dnum[k]     = {dmag[k][PROD_W-1:0], {FRAC_BITS{1'b0}}};
      rem_init[k] = dnum[k][NUM_W-1:QUO_W];
      trial[k]    = {rem[k], shf[k][QUO_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_state <= DV_IDLE;
    end else begin
      dv_state <= dv_state_next;
    end
  end

  always_comb begin
    dv_state_next = dv_state;
    unique case (dv_state)
      DV_IDLE: if (dv_start) dv_state_next = DV_RUN;
      DV_RUN:  if (cnt == CNT_W'(1)) dv_state_next = DV_DONE;
      DV_DONE: if (s1_adv) dv_state_next = DV_IDLE;
      default: dv_state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dv_start) begin
      cnt     <= CNT_W'(QUO_W);
      dneg[0] <= div_nr[ACC_W-1];
      dneg[1] <= div_ni[ACC_W-1];
      for (int k = 0; k < 2; k++) begin
        rem[k] <= PROD_W'(rem_init[k]);
        shf[k] <= dnum[k][QUO_W-1:0];
        quo[k] <= '0;
        // quotient would not fit in QUO_W bits
        big[k] <= (PROD_W'(rem_init[k]) >= den);
      end
    end else if (dv_state == DV_RUN) begin
      cnt <= cnt - CNT_W'(1);
      for (int k = 0; k < 2; k++) begin
        shf[k] <= shf[k] << 1;
        if (trial[k] >= {1'b0, den}) begin
          rem[k] <= PROD_W'(trial[k] - {1'b0, den});
          quo[k] <= {quo[k][QUO_W-2:0], 1'b1};
        end else begin
          rem[k] <= PROD_W'(trial[k]);
          quo[k] <= {quo[k][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    r_neg = 1'b0;
    i_neg = 1'b0;
    r_mag = '0;
    i_mag = '0;
    r_big = 1'b0;
    i_big = 1'b0;
    case (op1) inside
      OP_ADD, OP_SUB: begin
        r_neg = sum_re[DATA_W];
        i_neg = sum_im[DATA_W];
        r_mag = abs_acc(ACC_W'(sum_re));
        i_mag = abs_acc(ACC_W'(sum_im));
      end
      OP_MUL: begin
        r_neg = mul_re[ACC_W-1];
        i_neg = mul_im[ACC_W-1];
        r_mag = abs_acc(mul_re) >> FRAC_BITS;
        i_mag = abs_acc(mul_im) >> FRAC_BITS;
      end
      OP_DIV: begin
        r_neg = dneg[0];
        i_neg = dneg[1];
        r_mag = ACC_W'(quo[0]);
        i_mag = ACC_W'(quo[1]);
        r_big = big[0];
        i_big = big[1];
      end
      default: ;
    endcase
    r_sat = sat_mag(r_neg, r_mag, r_big);
    i_sat = sat_mag(i_neg, i_mag, i_big);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_re   <= r_sat.val;
      res_im   <= i_sat.val;
      overflow <= r_sat.ovf || i_sat.ovf;
      div_zero <= (op1 == OP_DZ);
    end
  end

endmodule

// ===== sv/complex_arithmetic_unit.sv =====
// Add, subtract, multiply and zero-divisor divides pass through the queue, the product
// stage register and the output register; a divide also runs a 32-step restoring divider.
// Throughput: one item per cycle for add, subtract, multiply and zero-divisor divides
// while out_stall is low; a divide holds the product stage until done, one at a time.
// Reset: synchronous, active high; clears the queue, pipeline and divider control.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide on signed fixed point operands.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        func,
  input  logic signed [cau_pkg::DATA_W-1:0] a_re,
  input  logic signed [cau_pkg::DATA_W-1:0] a_im,
  input  logic signed [cau_pkg::DATA_W-1:0] b_re,
  input  logic signed [cau_pkg::DATA_W-1:0] b_im,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cau_pkg::DATA_W-1:0] res_re,
  output logic signed [cau_pkg::DATA_W-1:0] res_im,
  output logic                              overflow,
  output logic                              div_zero
);
  import cau_pkg::*;

  logic  q_full, push, q_valid, q_pop;
  item_t push_item, q_item;

  cau_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .a_re      (a_re),
    .a_im      (a_im),
    .b_re      (b_re),
    .b_im      (b_im),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  cau_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_item)
  );

  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_re    (res_re),
    .res_im    (res_im),
    .overflow  (overflow),
    .div_zero  (div_zero)
  );

endmodule

// ===== sv/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the complex arithmetic unit result channel.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_macros.svh"

module cau_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [cau_pkg::DATA_W-1:0] res_re,
  input logic signed [cau_pkg::DATA_W-1:0] res_im,
  input logic                              overflow,
  input logic                              div_zero
);
  import cau_pkg::*;

  `CAU_ASSERT(a_dz_zero, out_valid && div_zero |-> res_re == '0 && res_im == '0, "div by zero result not zero")
  `CAU_ASSERT(a_dz_no_ovf, out_valid && div_zero |-> !overflow, "overflow with div by zero")
  `CAU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `CAU_ASSERT_STABLE(a_res_hold, res_re, "stalled result changed")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
